### rtl/pidmc_pkg.sv
`default_nettype none
package pidmc_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned AccW    = ProdW + 2;

  localparam int unsigned GainFracBitsDef = 8;

  localparam logic [LimitW-1:0] IntegralLimitRst = LimitW'(1000);
  localparam logic [LimitW-1:0] DriveLimitRst    = LimitW'(255);

  localparam logic [CfgIdxW-1:0] RegSetpoint      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFeedforward   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainFf        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainP         = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainI         = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGainD         = 3'd5;
  localparam logic [CfgIdxW-1:0] RegIntegralLimit = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDriveLimit    = 3'd7;

  typedef logic signed [DataW-1:0] sample_t;

  // saturate a 17-bit signed sum to 16 bits
  function automatic sample_t sat16(input logic signed [DataW:0] v);
    sample_t r;
    if (v > $signed({2'b00, {(DataW-1){1'b1}}})) begin
      r = sample_t'({1'b0, {(DataW-1){1'b1}}});
    end else if (v < $signed({2'b11, {(DataW-1){1'b0}}})) begin
      r = sample_t'({1'b1, {(DataW-1){1'b0}}});
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pid_motor_controller.sv
`default_nettype none
// PID drive controller with feedforward and anti-windup. Each request on the
// in_ channel carries one measured value and yields exactly one drive request
// on the out_ channel via the input and result registers. A new request is
// taken every cycle while out_stall is low: the pass from the input register to
// the result register holds four parallel 16x16 multipliers, their 34-bit sum
// and the drive-limit compare, and the integral and previous-value registers
// update in that same cycle, so consecutive requests see each other's state.
// Gains are signed with GAIN_FRAC_BITS fraction bits; the drive is clamped to
// +/-drive_limit and truncated toward zero. Write the cfg_ registers only
// while no request is in flight.
module pid_motor_controller
  import pidmc_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = GainFracBitsDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [DataW-1:0]   in_measured,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [DataW-1:0]        out_drive,
  output logic                           out_saturated,
  input  wire logic                      cfg_we,
  input  wire logic [CfgIdxW-1:0]        cfg_index,
  input  wire logic [DataW-1:0]          cfg_data
);

  // configuration
  sample_t             setpoint_r;
  sample_t             feedforward_r;
  sample_t             gain_ff_r;
  sample_t             gain_p_r;
  sample_t             gain_i_r;
  sample_t             gain_d_r;
  logic [LimitW-1:0]   integral_limit_r;
  logic [LimitW-1:0]   drive_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r       <= '0;
      feedforward_r    <= '0;
      gain_ff_r        <= '0;
      gain_p_r         <= '0;
      gain_i_r         <= '0;
      gain_d_r         <= '0;
      integral_limit_r <= IntegralLimitRst;
      drive_limit_r    <= DriveLimitRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSetpoint:      setpoint_r       <= cfg_data;
        RegFeedforward:   feedforward_r    <= cfg_data;
        RegGainFf:        gain_ff_r        <= cfg_data;
        RegGainP:         gain_p_r         <= cfg_data;
        RegGainI:         gain_i_r         <= cfg_data;
        RegGainD:         gain_d_r         <= cfg_data;
        RegIntegralLimit: integral_limit_r <= cfg_data[LimitW-1:0];
        RegDriveLimit:    drive_limit_r    <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    s1_valid_r;
  sample_t s1_meas_r;
  logic    out_valid_r;
  logic    adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_meas_r <= in_measured;
    end
  end

  // datapath
  sample_t prev_meas_r;
  sample_t integral_sum_r;

  sample_t                err;
  sample_t                deriv;
  sample_t                integ_pre;
  sample_t                integ;
  sample_t                integ_next;
  logic signed [DataW:0]  int_lim_s;
  logic signed [ProdW-1:0] p_ff, p_p, p_i, p_d;
  logic signed [AccW-1:0] acc;
  logic                   acc_neg;
  logic [AccW-1:0]        mag;
  logic [AccW-1:0]        lim_scaled;
  logic                   sat;
  logic [AccW-1:0]        mag_sh;
  logic [DataW-1:0]       mag_int;
  logic [DataW-1:0]       lim_ext;
  sample_t                drive;
  logic [DataW:0]         abs_int;
  logic                   grow;

  always_comb begin
    err   = sat16({setpoint_r[DataW-1], setpoint_r} - {s1_meas_r[DataW-1], s1_meas_r});
    deriv = sat16({s1_meas_r[DataW-1], s1_meas_r} - {prev_meas_r[DataW-1], prev_meas_r});
    integ_next = sat16({integral_sum_r[DataW-1], integral_sum_r} + {err[DataW-1], err});
    integ_pre  = integ_next;

    int_lim_s = $signed({2'b00, integral_limit_r});
    if ($signed({integ_pre[DataW-1], integ_pre}) > int_lim_s) begin
      integ = int_lim_s[DataW-1:0];
    end else if ($signed({integ_pre[DataW-1], integ_pre}) < -int_lim_s) begin
      integ = sample_t'(-int_lim_s);
    end else begin
      integ = integ_pre;
    end

    p_ff = gain_ff_r * feedforward_r;
    p_p  = gain_p_r * err;
    p_i  = gain_i_r * integ;
    p_d  = gain_d_r * deriv;
    acc  = AccW'(p_ff) + AccW'(p_p) + AccW'(p_i) + AccW'(p_d);

    acc_neg    = acc[AccW-1];
    mag        = acc_neg ? AccW'(-acc) : AccW'(acc);
    lim_scaled = AccW'(drive_limit_r) << GAIN_FRAC_BITS;
    sat        = mag >= lim_scaled;

    mag_sh  = mag >> GAIN_FRAC_BITS;
    mag_int = mag_sh[DataW-1:0];
    lim_ext = {1'b0, drive_limit_r};
    if (sat) begin
      drive = acc_neg ? sample_t'(-lim_ext) : sample_t'(lim_ext);
    end else begin
      drive = acc_neg ? sample_t'(-mag_int) : sample_t'(mag_int);
    end

    abs_int = integral_sum_r[DataW-1] ? (DataW+1)'(-{integral_sum_r[DataW-1], integral_sum_r})
                                      : {1'b0, integral_sum_r};
    grow    = !sat && (abs_int < {2'b00, integral_limit_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r    <= '0;
      integral_sum_r <= '0;
    end else if (s1_valid_r && adv) begin
      prev_meas_r <= s1_meas_r;
      if (grow) begin
        integral_sum_r <= integ_next;
      end
    end
  end

  // result register
  sample_t drive_r;
  logic    sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      drive_r <= drive;
      sat_r   <= sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;
  assign out_saturated = sat_r;

endmodule
`default_nettype wire

### test/pid_motor_controller_tb.sv
module pid_motor_controller_tb;
  import pidmc_pkg::*;

  localparam int FracBits   = GainFracBitsDef;
  localparam int StuckLimit = 400;
  localparam int RandPhases = 12;
  localparam int PhaseTicks = 96;

  typedef struct packed {
    sample_t drive;
    logic    saturated;
  } drive_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sample_t             in_measured = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sample_t             out_drive;
  logic                out_saturated;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [DataW-1:0]    cfg_data = '0;

  // shadow copy of the controller settings and loop state
  sample_t             sp, ffv, g_ff, g_p, g_i, g_d;
  logic [LimitW-1:0]   ilim, dlim;
  int                  prev_meas;
  int                  isum;

  sample_t             queued_samples[$];
  drive_result_t       pending_drives[$];
  int                  mismatches = 0;
  int                  send_gap = 0;
  int                  hold_cnt = 0;
  int                  stuck = 0;
  bit                  calm = 1'b0;

  pid_motor_controller uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_measured(in_measured),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void compute_drive(input sample_t meas);
    int     err, deriv, integ, ilim_i, dlim_i, drv, abs_sum;
    longint acc, mag;
    bit     neg, sat;
    drive_result_t r;
    ilim_i = int'(ilim);
    dlim_i = int'(dlim);
    err   = clip16(longint'(sp) - longint'(meas));
    deriv = clip16(longint'(meas) - longint'(prev_meas));
    integ = clip16(longint'(isum) + longint'(err));
    if (integ > ilim_i) integ = ilim_i;
    else if (integ < -ilim_i) integ = -ilim_i;
    acc = longint'(g_ff) * longint'(ffv) + longint'(g_p) * longint'(err)
        + longint'(g_i) * longint'(integ) + longint'(g_d) * longint'(deriv);
    neg = acc < 0;
    mag = neg ? -acc : acc;
    sat = mag >= (longint'(dlim_i) <<< FracBits);
    drv = sat ? dlim_i : int'(mag >>> FracBits);
    if (neg) drv = -drv;
    abs_sum = isum < 0 ? -isum : isum;
    if (!sat && abs_sum < ilim_i) isum = clip16(longint'(isum) + longint'(err));
    prev_meas = int'(meas);
    r.drive = sample_t'(drv);
    r.saturated = sat;
    pending_drives.push_back(r);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        compute_drive(in_measured);
        send_gap = calm ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_samples.size() > 0) begin
          in_valid <= 1'b1;
          in_measured <= queued_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    drive_result_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected drive request: drive %0d saturated %0b",
                     out_drive, out_saturated);
        end else begin
          exp_r = pending_drives.pop_front();
          if (out_drive !== exp_r.drive || out_saturated !== exp_r.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive mismatch: expected %0d/%0b got %0d/%0b",
                       exp_r.drive, exp_r.saturated, out_drive, out_saturated);
          end
        end
        hold_cnt = calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        if (out_valid) hold_cnt--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    while (stuck < StuckLimit) begin
      @(posedge clk);
      if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)) &&
          (queued_samples.size() > 0 || in_valid || pending_drives.size() > 0))
        stuck++;
      else
        stuck = 0;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // wait for the loop to go idle, returns at a rising edge
  task automatic drain();
    do @(negedge clk);
    while (queued_samples.size() != 0 || in_valid || pending_drives.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // call at a rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegSetpoint:      sp   = sample_t'(val);
      RegFeedforward:   ffv  = sample_t'(val);
      RegGainFf:        g_ff = sample_t'(val);
      RegGainP:         g_p  = sample_t'(val);
      RegGainI:         g_i  = sample_t'(val);
      RegGainD:         g_d  = sample_t'(val);
      RegIntegralLimit: ilim = val[LimitW-1:0];
      RegDriveLimit:    dlim = val[LimitW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] rand_gain();
    int pick;
    logic [DataW-1:0] v;
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2, 3: v = DataW'($urandom);
      default: v = DataW'($urandom_range(0, 1024) - 512);
    endcase
    return v;
  endfunction

  function automatic logic [DataW-1:0] rand_limit();
    int pick;
    logic [DataW-1:0] v;
    pick = $urandom_range(0, 7);
    case (pick)
      0: v = 16'h0000;
      1: v = 16'h7fff;
      2: v = DataW'($urandom);
      default: v = DataW'($urandom_range(1, 2000));
    endcase
    v[DataW-1] = $urandom_range(0, 1);
    return v;
  endfunction

  task automatic pick_settings(input int ph);
    if (ph == 0) begin
      write_reg(RegSetpoint, 16'h7fff);
      write_reg(RegFeedforward, 16'h8000);
      write_reg(RegGainFf, 16'h8000);
      write_reg(RegGainP, 16'h7fff);
      write_reg(RegGainI, 16'h7fff);
      write_reg(RegGainD, 16'h7fff);
      write_reg(RegIntegralLimit, 16'hffff);
      write_reg(RegDriveLimit, 16'hffff);
    end else begin
      write_reg(RegSetpoint, ($urandom_range(0, 1) == 1) ? DataW'($urandom)
                                                       : DataW'($urandom_range(0, 4000) - 2000));
      write_reg(RegFeedforward, ($urandom_range(0, 2) == 0) ? DataW'($urandom)
                                                          : DataW'($urandom_range(0, 512) - 256));
      write_reg(RegGainFf, rand_gain());
      write_reg(RegGainP, rand_gain());
      write_reg(RegGainI, rand_gain());
      write_reg(RegGainD, rand_gain());
      write_reg(RegIntegralLimit, (ph == 1) ? 16'h8000 : rand_limit());
      write_reg(RegDriveLimit, (ph == 1) ? 16'h8000 : rand_limit());
    end
    cfg_we <= 1'b0;
  endtask

  // mostly a slow walk around the target, with jumps and extremes
  function automatic sample_t next_sample(inout int walk);
    int pick;
    sample_t m;
    pick = $urandom_range(0, 19);
    case (pick)
      0: m = 16'sh7fff;
      1: m = 16'sh8000;
      2, 3, 4, 5: m = sample_t'($urandom);
      default: m = sample_t'(clip16(longint'(walk) + $urandom_range(0, 64) - 32));
    endcase
    walk = int'(m);
    return m;
  endfunction

  initial begin
    int walk;
    sp = '0; ffv = '0; g_ff = '0; g_p = '0; g_i = '0; g_d = '0;
    ilim = IntegralLimitRst;
    dlim = DriveLimitRst;
    prev_meas = 0;
    isum = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits and target, gains only
    write_reg(RegGainP, 16'd256);
    write_reg(RegGainI, 16'd64);
    write_reg(RegGainD, 16'd128);
    cfg_we <= 1'b0;
    @(negedge clk);
    queued_samples.push_back(16'sd0);     queued_samples.push_back(16'sd100);
    queued_samples.push_back(-16'sd100);  queued_samples.push_back(16'sh7fff);
    queued_samples.push_back(16'sh8000);  queued_samples.push_back(16'sh7fff);
    queued_samples.push_back(16'sd500);   queued_samples.push_back(16'sd1200);

    // all extremes, saturating differences
    drain();
    write_reg(RegSetpoint, 16'h8000);
    write_reg(RegFeedforward, 16'h7fff);
    write_reg(RegGainFf, 16'h7fff);
    write_reg(RegGainP, 16'h8000);
    write_reg(RegGainI, 16'h7fff);
    write_reg(RegGainD, 16'h8000);
    write_reg(RegIntegralLimit, 16'h7fff);
    write_reg(RegDriveLimit, 16'h7fff);
    cfg_we <= 1'b0;
    @(negedge clk);
    queued_samples.push_back(16'sh7fff);  queued_samples.push_back(16'sh8000);
    queued_samples.push_back(16'sd0);     queued_samples.push_back(-16'sd1);
    queued_samples.push_back(16'sh7fff);

    // zero drive limit and zero integral limit
    drain();
    write_reg(RegSetpoint, 16'd0);
    write_reg(RegGainP, 16'd256);
    write_reg(RegGainI, 16'd256);
    write_reg(RegGainD, 16'd0);
    write_reg(RegGainFf, 16'd0);
    write_reg(RegIntegralLimit, 16'd0);
    write_reg(RegDriveLimit, 16'd0);
    cfg_we <= 1'b0;
    @(negedge clk);
    queued_samples.push_back(16'sd10);    queued_samples.push_back(-16'sd10);
    queued_samples.push_back(16'sd0);     queued_samples.push_back(16'sh7fff);

    // truncation toward zero
    drain();
    write_reg(RegGainP, 16'd1);
    write_reg(RegDriveLimit, 16'h7fff);
    cfg_we <= 1'b0;
    @(negedge clk);
    queued_samples.push_back(16'sd1);     queued_samples.push_back(-16'sd1);
    queued_samples.push_back(16'sd257);   queued_samples.push_back(-16'sd257);
    queued_samples.push_back(16'sh8000);

    for (int ph = 0; ph < RandPhases; ph++) begin
      drain();
      pick_settings(ph);
      @(negedge clk);
      calm = (ph % 4 == 3);
      walk = int'(sp);
      for (int k = 0; k < PhaseTicks; k++) begin
        if (ph == 5 && k == PhaseTicks / 2) begin
          drain();
          @(negedge clk);
        end
        queued_samples.push_back(next_sample(walk));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
